// ===== design/erar_pkg.sv =====
// Shared types, constants, sine table and angle helpers for the anchor regrounding core.
package erar_pkg;

    localparam int SINE_FRAC_BITS = 14;
    localparam int COUNT_BITS     = 16;

    localparam int SINE_W  = SINE_FRAC_BITS + 2;
    localparam int VEC_W   = 35;
    localparam int PROD_W  = VEC_W + SINE_W;
    localparam int ACC_W   = PROD_W + 1;
    localparam int ANGLE_W = 9;
    localparam int CMP_W   = (COUNT_BITS > 16) ? COUNT_BITS : 16;

    localparam int IN_DATA_W  = 320;
    localparam int OUT_DATA_W = 136;

    localparam logic [63:0] PI_Q30 = 64'd3373259426;

    typedef logic signed [SINE_W-1:0] sine_t;
    typedef logic signed [VEC_W-1:0]  vec_t;
    typedef logic [ANGLE_W-1:0]       angle_t;
    typedef logic [1:0]               rot_t;
    typedef logic [2:0]               step_t;
    typedef sine_t                    sine_table_t [91];

    localparam rot_t ROT_ROLL  = 2'd0;
    localparam rot_t ROT_PITCH = 2'd1;
    localparam rot_t ROT_YAW   = 2'd2;

    localparam step_t STEP_NA   = 3'd3;
    localparam step_t STEP_LAST = 3'd5;

    localparam logic [1:0] REG_MOVE_EPSILON  = 2'd0;
    localparam logic [1:0] REG_WRITE_BACK_EN = 2'd1;
    localparam logic [1:0] REG_BATCH_LENGTH  = 2'd2;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PREP,
        ST_ROT,
        ST_SAT,
        ST_FINISH
    } state_t;

    typedef enum logic [1:0] {
        ACC_HOLD,
        ACC_LOAD,
        ACC_ADD,
        ACC_SUB
    } acc_op_t;

    typedef enum logic [1:0] {
        MUL_CA,
        MUL_SB,
        MUL_SA,
        MUL_CB
    } mul_sel_t;

    typedef struct packed {
        logic     capture;
        logic     load_trig;
        rot_t     trig_sel;
        logic     issue;
        mul_sel_t mul_sel;
        acc_op_t  acc_op;
        logic     hold_na;
        logic     write_pair;
        rot_t     rot;
        logic     sat_en;
        logic     load_out;
    } ctrl_t;

    function automatic sine_t sine_quarter_calc(input int k);
        logic [63:0]        x;
        logic [63:0]        x2;
        logic [63:0]        term;
        logic [63:0]        mag;
        logic signed [63:0] sum;
        x    = (64'(k) * PI_Q30 + 64'd90) / 64'd180;
        x2   = (x * x) >> 30;
        term = x;
        sum  = signed'(x);
        term = ((term * x2) >> 30) / 64'd6;
        sum  = sum - signed'(term);
        term = ((term * x2) >> 30) / 64'd20;
        sum  = sum + signed'(term);
        term = ((term * x2) >> 30) / 64'd42;
        sum  = sum - signed'(term);
        term = ((term * x2) >> 30) / 64'd72;
        sum  = sum + signed'(term);
        term = ((term * x2) >> 30) / 64'd110;
        sum  = sum - signed'(term);
        term = ((term * x2) >> 30) / 64'd156;
        sum  = sum + signed'(term);
        term = ((term * x2) >> 30) / 64'd210;
        sum  = sum - signed'(term);
        term = ((term * x2) >> 30) / 64'd272;
        sum  = sum + signed'(term);
        term = ((term * x2) >> 30) / 64'd342;
        sum  = sum - signed'(term);
        term = ((term * x2) >> 30) / 64'd420;
        sum  = sum + signed'(term);
        if (sum < 64'sd0) begin
            sum = 64'sd0;
        end
        mag = (unsigned'(sum) + (64'd1 << (30 - SINE_FRAC_BITS - 1))) >> (30 - SINE_FRAC_BITS);
        return SINE_W'(mag);
    endfunction

    function automatic sine_table_t build_sine_table();
        sine_table_t t;
        for (int k = 0; k <= 90; k++) begin
            t[k] = sine_quarter_calc(k);
        end
        return t;
    endfunction

    localparam sine_table_t SINE_TABLE = build_sine_table();

    function automatic sine_t sine_deg(input angle_t d);
        angle_t idx;
        logic   neg;
        if (d <= 9'd90) begin
            idx = d;
            neg = 1'b0;
        end else if (d <= 9'd180) begin
            idx = 9'd180 - d;
            neg = 1'b0;
        end else if (d <= 9'd270) begin
            idx = d - 9'd180;
            neg = 1'b1;
        end else begin
            idx = 9'd360 - d;
            neg = 1'b1;
        end
        return neg ? -SINE_TABLE[idx[6:0]] : SINE_TABLE[idx[6:0]];
    endfunction

    function automatic sine_t cos_deg(input angle_t d);
        angle_t shifted;
        shifted = (d >= 9'd270) ? d - 9'd270 : d + 9'd90;
        return sine_deg(shifted);
    endfunction

    function automatic angle_t reduce_deg(input logic signed [9:0] v);
        logic signed [10:0] r;
        r = 11'(v);
        if (r < 11'sd0) begin
            r = r + 11'sd360;
        end
        if (r < 11'sd0) begin
            r = r + 11'sd360;
        end
        if (r >= 11'sd360) begin
            r = r - 11'sd360;
        end
        return ANGLE_W'(r);
    endfunction

endpackage

// ===== design/erar_mac.sv =====
// Shared multiplier and accumulator with round-to-nearest scaling of the Q2.14 sine products back to the operand scale.
module erar_mac import erar_pkg::*; (
    input  logic    aclk,
    input  logic    issue,
    input  sine_t   coef,
    input  vec_t    operand,
    input  acc_op_t acc_op,
    output vec_t    rounded
);

    localparam logic [ACC_W-1:0] ROUND_HALF = ACC_W'(1) << (SINE_FRAC_BITS - 1);

    logic signed [PROD_W-1:0] prod_reg;
    logic signed [ACC_W-1:0]  acc_reg;
    logic                     neg;
    logic [ACC_W-1:0]         mag;
    logic [ACC_W-1:0]         rnd;
    logic [ACC_W-1:0]         res;

    always_ff @(posedge aclk) begin
        if (issue) begin
            prod_reg <= PROD_W'(coef) * PROD_W'(operand);
        end
        unique case (acc_op)
            ACC_LOAD: acc_reg <= ACC_W'(prod_reg);
            ACC_ADD:  acc_reg <= acc_reg + ACC_W'(prod_reg);
            ACC_SUB:  acc_reg <= acc_reg - ACC_W'(prod_reg);
            default:  acc_reg <= acc_reg;
        endcase
    end

    always_comb begin
        neg     = acc_reg[ACC_W-1];
        mag     = neg ? -unsigned'(acc_reg) : unsigned'(acc_reg);
        rnd     = (mag + ROUND_HALF) >> SINE_FRAC_BITS;
        res     = neg ? -rnd : rnd;
        rounded = VEC_W'(signed'(res));
    end

endmodule

// ===== design/erar_fsm.sv =====
// Sequencer that steps the shared multiplier through the three rotations of one request.
module erar_fsm import erar_pkg::*; (
    input  logic  aclk,
    input  logic  aresetn,
    input  logic  s_tvalid,
    input  logic  out_free,
    output logic  s_tready,
    output ctrl_t ctrl
);

    state_t state_reg, state_next;
    step_t  step_reg, step_next;
    rot_t   rot_reg, rot_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            step_reg  <= '0;
            rot_reg   <= ROT_ROLL;
        end else begin
            state_reg <= state_next;
            step_reg  <= step_next;
            rot_reg   <= rot_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        step_next  = step_reg;
        rot_next   = rot_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    state_next = ST_PREP;
                end
            end
            ST_PREP: begin
                state_next = ST_ROT;
                step_next  = '0;
                rot_next   = ROT_ROLL;
            end
            ST_ROT: begin
                if (step_reg == STEP_LAST) begin
                    step_next = '0;
                    if (rot_reg == ROT_YAW) begin
                        state_next = ST_SAT;
                    end else begin
                        rot_next = rot_reg + 2'd1;
                    end
                end else begin
                    step_next = step_reg + 3'd1;
                end
            end
            ST_SAT: begin
                state_next = ST_FINISH;
            end
            ST_FINISH: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        s_tready        = 1'b0;
        ctrl            = '0;
        ctrl.mul_sel    = MUL_CA;
        ctrl.acc_op     = ACC_HOLD;
        ctrl.rot        = rot_reg;
        ctrl.trig_sel   = rot_reg + 2'd1;
        unique case (state_reg)
            ST_IDLE: begin
                s_tready     = 1'b1;
                ctrl.capture = s_tvalid;
            end
            ST_PREP: begin
                ctrl.load_trig = 1'b1;
                ctrl.trig_sel  = ROT_ROLL;
            end
            ST_ROT: begin
                ctrl.issue      = (step_reg <= STEP_NA);
                ctrl.hold_na    = (step_reg == STEP_NA);
                ctrl.write_pair = (step_reg == STEP_LAST);
                ctrl.load_trig  = (step_reg == STEP_LAST) && (rot_reg != ROT_YAW);
                unique case (step_reg)
                    3'd0: ctrl.mul_sel = MUL_CA;
                    3'd1: ctrl.mul_sel = MUL_SB;
                    3'd2: ctrl.mul_sel = MUL_SA;
                    3'd3: ctrl.mul_sel = MUL_CB;
                    default: ctrl.mul_sel = MUL_CA;
                endcase
                unique case (step_reg)
                    3'd1: ctrl.acc_op = ACC_LOAD;
                    3'd2: ctrl.acc_op = ACC_SUB;
                    3'd3: ctrl.acc_op = ACC_LOAD;
                    3'd4: ctrl.acc_op = ACC_ADD;
                    default: ctrl.acc_op = ACC_HOLD;
                endcase
            end
            ST_SAT: begin
                ctrl.sat_en = 1'b1;
            end
            ST_FINISH: begin
                ctrl.load_out = out_free;
            end
            default: begin
                s_tready = 1'b0;
            end
        endcase
    end

endmodule

// ===== design/euler_rotated_anchor_reground_core.sv =====
// Top level of the anchor regrounding core: registers, rotation datapath, move test and counters.
// An accepted transaction passes through PREP, three rotations in ROT, SAT and FINISH, and m_tvalid
// rises once FINISH finds the output register free. No new transaction is accepted until then: the
// single shared multiplier forms four products per rotation over three rotations.
// A finished result waits in the output register while the next transaction is accepted.
// Reset: synchronous, active-low aresetn clears the sequencer, output valid, counters and
// configuration registers (move_epsilon 1, write_back_enable 0, batch_length 1).
module euler_rotated_anchor_reground_core import erar_pkg::*; (
    input  logic                  aclk,
    input  logic                  aresetn,
    // s_tdata from bit 0 up: pitch, yaw and roll angles, cur_x, cur_y, cur_z,
    // hit_x, hit_y, hit_z, anchor_x, anchor_y, anchor_z, zero fill.
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [IN_DATA_W-1:0]  s_tdata,
    // m_tdata from bit 0 up: target_x, target_y, target_z, moved, write_request,
    // row_index, moved_total, zero fill.
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [OUT_DATA_W-1:0] m_tdata,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [3:0]            paddr,
    input  logic [31:0]           pwdata,
    output logic [31:0]           prdata,
    output logic                  pready
);

    ctrl_t ctrl;
    logic  out_free;

    logic [30:0]           move_epsilon_reg;
    logic                  write_back_enable_reg;
    logic [15:0]           batch_length_reg;
    logic [COUNT_BITS-1:0] request_counter_reg;
    logic [COUNT_BITS-1:0] moved_counter_reg;

    angle_t roll_reg, pitch_reg, yaw_reg;
    angle_t roll_in, pitch_in, yaw_in, trig_angle;
    sine_t  sin_reg, cos_reg, coef;

    logic signed [31:0] cur_reg [3];
    logic signed [31:0] hit_reg [3];
    logic signed [31:0] target_reg [3];
    vec_t               v_reg [3];
    vec_t               na_reg;
    vec_t               op_a, op_b, operand, rounded;

    logic signed [35:0] sat_diff [3];
    logic signed [32:0] move_diff [3];
    logic [32:0]        move_abs [3];
    logic               moved;
    logic [COUNT_BITS-1:0] request_inc, moved_new;

    logic                  m_tvalid_reg;
    logic [OUT_DATA_W-1:0] out_data_reg;

    logic cfg_write;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            move_epsilon_reg      <= 31'd1;
            write_back_enable_reg <= 1'b0;
            batch_length_reg      <= 16'd1;
        end else if (cfg_write) begin
            unique case (paddr[3:2])
                REG_MOVE_EPSILON:  move_epsilon_reg      <= pwdata[30:0];
                REG_WRITE_BACK_EN: write_back_enable_reg <= pwdata[0];
                REG_BATCH_LENGTH:  batch_length_reg      <= pwdata[15:0];
                default:           move_epsilon_reg      <= move_epsilon_reg;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[3:2])
            REG_MOVE_EPSILON:  prdata = {1'b0, move_epsilon_reg};
            REG_WRITE_BACK_EN: prdata = {31'd0, write_back_enable_reg};
            REG_BATCH_LENGTH:  prdata = {16'd0, batch_length_reg};
            default:           prdata = '0;
        endcase
    end

    erar_fsm u_fsm (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .out_free (out_free),
        .s_tready (s_tready),
        .ctrl     (ctrl)
    );

    // Pitch enters as its negative and yaw as ninety degrees minus yaw.
    always_comb begin
        pitch_in = reduce_deg(s_tdata[9:0]);
        yaw_in   = reduce_deg(s_tdata[19:10]);
        roll_in  = reduce_deg(s_tdata[29:20]);
    end

    always_ff @(posedge aclk) begin
        if (ctrl.capture) begin
            roll_reg   <= roll_in;
            pitch_reg  <= (pitch_in == '0) ? '0 : 9'd360 - pitch_in;
            yaw_reg    <= (yaw_in <= 9'd90) ? 9'd90 - yaw_in : 9'd450 - yaw_in;
            cur_reg[0] <= s_tdata[61:30];
            cur_reg[1] <= s_tdata[93:62];
            cur_reg[2] <= s_tdata[125:94];
            hit_reg[0] <= s_tdata[157:126];
            hit_reg[1] <= s_tdata[189:158];
            hit_reg[2] <= s_tdata[221:190];
        end
    end

    always_comb begin
        unique case (ctrl.trig_sel)
            ROT_ROLL:  trig_angle = roll_reg;
            ROT_PITCH: trig_angle = pitch_reg;
            default:   trig_angle = yaw_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (ctrl.load_trig) begin
            sin_reg <= sine_deg(trig_angle);
            cos_reg <= cos_deg(trig_angle);
        end
    end

    always_comb begin
        unique case (ctrl.rot)
            ROT_ROLL: begin
                op_a = v_reg[1];
                op_b = v_reg[2];
            end
            ROT_PITCH: begin
                op_a = v_reg[2];
                op_b = v_reg[0];
            end
            default: begin
                op_a = v_reg[0];
                op_b = v_reg[1];
            end
        endcase
        coef    = (ctrl.mul_sel == MUL_CA || ctrl.mul_sel == MUL_CB) ? cos_reg : sin_reg;
        operand = (ctrl.mul_sel == MUL_CA || ctrl.mul_sel == MUL_SA) ? op_a : op_b;
    end

    erar_mac u_mac (
        .aclk    (aclk),
        .issue   (ctrl.issue),
        .coef    (coef),
        .operand (operand),
        .acc_op  (ctrl.acc_op),
        .rounded (rounded)
    );

    // The fixed quarter turn about z is applied while the anchor is captured.
    always_ff @(posedge aclk) begin
        if (ctrl.capture) begin
            v_reg[0] <= -VEC_W'($signed(s_tdata[285:254]));
            v_reg[1] <= VEC_W'($signed(s_tdata[253:222]));
            v_reg[2] <= VEC_W'($signed(s_tdata[317:286]));
        end else if (ctrl.write_pair) begin
            unique case (ctrl.rot)
                ROT_ROLL: begin
                    v_reg[1] <= na_reg;
                    v_reg[2] <= rounded;
                end
                ROT_PITCH: begin
                    v_reg[2] <= na_reg;
                    v_reg[0] <= rounded;
                end
                default: begin
                    v_reg[0] <= na_reg;
                    v_reg[1] <= rounded;
                end
            endcase
        end
        if (ctrl.hold_na) begin
            na_reg <= rounded;
        end
    end

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            sat_diff[i]  = 36'(hit_reg[i]) - 36'(v_reg[i]);
            move_diff[i] = 33'(target_reg[i]) - 33'(cur_reg[i]);
            move_abs[i]  = move_diff[i][32] ? -unsigned'(move_diff[i]) : unsigned'(move_diff[i]);
        end
        moved = (move_abs[0] > {2'b00, move_epsilon_reg})
             || (move_abs[1] > {2'b00, move_epsilon_reg})
             || (move_abs[2] > {2'b00, move_epsilon_reg});
    end

    always_ff @(posedge aclk) begin
        if (ctrl.sat_en) begin
            for (int i = 0; i < 3; i++) begin
                if (sat_diff[i] > 36'sh0_7FFF_FFFF) begin
                    target_reg[i] <= 32'sh7FFF_FFFF;
                end else if (sat_diff[i] < -36'sh0_8000_0000) begin
                    target_reg[i] <= 32'sh8000_0000;
                end else begin
                    target_reg[i] <= sat_diff[i][31:0];
                end
            end
        end
    end

    assign request_inc = request_counter_reg + COUNT_BITS'(1);
    assign moved_new   = moved ? moved_counter_reg + COUNT_BITS'(1) : moved_counter_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            request_counter_reg <= '0;
            moved_counter_reg   <= '0;
        end else if (ctrl.load_out) begin
            if (CMP_W'(request_inc) == CMP_W'(batch_length_reg)) begin
                request_counter_reg <= '0;
                moved_counter_reg   <= '0;
            end else begin
                request_counter_reg <= request_inc;
                moved_counter_reg   <= moved_new;
            end
        end
    end

    assign out_free = !m_tvalid_reg || m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (ctrl.load_out) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (ctrl.load_out) begin
            out_data_reg <= {6'd0, 16'(moved_new), 16'(request_counter_reg),
                             moved && write_back_enable_reg, moved,
                             target_reg[2], target_reg[1], target_reg[0]};
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = out_data_reg;

endmodule

// ===== design/erar_checker.sv =====
// Port-level assertions for the anchor regrounding core and the bind that attaches them.
module erar_port_asserts import erar_pkg::*; (
    input logic                  aclk,
    input logic                  aresetn,
    input logic                  s_tvalid,
    input logic                  s_tready,
    input logic                  m_tvalid,
    input logic                  m_tready,
    input logic [OUT_DATA_W-1:0] m_tdata
);

    // An accepted transaction keeps the block busy on the following cycle.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("input accepted on back-to-back cycles");

    // A new result only appears at the end of a busy period.
    assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> !$past(s_tready))
        else $error("result appeared without a computation in progress");

    // A stalled result transaction holds its valid and payload.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
        else $error("stalled result changed");

    // A write request is only raised for a moved target.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (!m_tdata[97] || m_tdata[96]))
        else $error("write request without move");

endmodule

bind euler_rotated_anchor_reground_core erar_port_asserts u_erar_checker (.*);

// ===== dv/erar_checker.sv =====
// Checker for the regrounding core: predicts each result transaction and compares it field by field.
module erar_checker import erar_pkg::*; (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    input  logic                  s_tready,
    input  logic [IN_DATA_W-1:0]  s_tdata,
    input  logic                  m_tvalid,
    input  logic                  m_tready,
    input  logic [OUT_DATA_W-1:0] m_tdata,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [3:0]            paddr,
    input  logic [31:0]           pwdata,
    input  logic                  pready,
    output int                    fail_count,
    output int                    pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        logic [31:0] target_x;
        logic [31:0] target_y;
        logic [31:0] target_z;
        logic        moved;
        logic        write_request;
        logic [15:0] row_index;
        logic [15:0] moved_total;
    } reground_result_t;

    logic [30:0]      eps_r;
    logic             wb_en_r;
    logic [15:0]      batch_len_r;
    logic [15:0]      req_cnt;
    logic [15:0]      mov_cnt;
    logic [15:0]      next_req;
    logic [15:0]      next_mov;
    longint           sine_lut [91];
    reground_result_t expected_targets [$];
    reground_result_t want;
    int               fails = 0;

    assign fail_count = fails;

    function automatic longint round_half_away(input longint v, input int sh);
        longint half;
        half = longint'(1) <<< (sh - 1);
        if (v >= 0) begin
            return (v + half) >>> sh;
        end
        return -((half - v) >>> sh);
    endfunction

    function automatic longint quarter_sine(input int k);
        longint unsigned x;
        longint unsigned x2;
        longint unsigned term;
        longint          acc;
        x    = (64'(k) * 64'd3373259426 + 64'd90) / 64'd180;
        x2   = (x * x) >> 30;
        term = x;
        acc  = longint'(x);
        for (int n = 1; n <= 10; n++) begin
            term = (term * x2) >> 30;
            term = term / 64'(2 * n * (2 * n + 1));
            if (n % 2 == 1) begin
                acc = acc - longint'(term);
            end else begin
                acc = acc + longint'(term);
            end
        end
        if (acc < 0) begin
            acc = 0;
        end
        return round_half_away(acc, 30 - SINE_FRAC_BITS);
    endfunction

    initial begin
        for (int k = 0; k <= 90; k++) begin
            sine_lut[k] = quarter_sine(k);
        end
    end

    function automatic int wrap360(input int v);
        int r;
        r = v % 360;
        if (r < 0) begin
            r += 360;
        end
        return r;
    endfunction

    function automatic longint sine_at(input int d);
        if (d <= 90) begin
            return sine_lut[d];
        end
        if (d <= 180) begin
            return sine_lut[180 - d];
        end
        if (d <= 270) begin
            return -sine_lut[d - 180];
        end
        return -sine_lut[360 - d];
    endfunction

    function automatic void turn_pair(inout longint a, inout longint b, input int deg);
        longint s;
        longint c;
        longint na;
        longint nb;
        s  = sine_at(deg);
        c  = sine_at((deg + 90) % 360);
        na = round_half_away(c * a - s * b, SINE_FRAC_BITS);
        nb = round_half_away(s * a + c * b, SINE_FRAC_BITS);
        a  = na;
        b  = nb;
    endfunction

    function automatic longint clamp32(input longint v);
        if (v > 64'sd2147483647) begin
            return 64'sd2147483647;
        end
        if (v < -64'sd2147483648) begin
            return -64'sd2147483648;
        end
        return v;
    endfunction

    function automatic reground_result_t predict_reground(input logic [IN_DATA_W-1:0] d);
        reground_result_t  r;
        logic signed [9:0] pitch_f;
        logic signed [9:0] yaw_f;
        logic signed [9:0] roll_f;
        longint            cur [3];
        longint            hit [3];
        longint            v [3];
        longint            t [3];
        longint            diff;
        int                pitch;
        int                yaw;
        int                roll;
        logic              mv;
        pitch_f = d[9:0];
        yaw_f   = d[19:10];
        roll_f  = d[29:20];
        pitch   = wrap360(int'(pitch_f));
        yaw     = wrap360(int'(yaw_f));
        roll    = wrap360(int'(roll_f));
        for (int i = 0; i < 3; i++) begin
            cur[i] = longint'($signed(d[30 + 32 * i +: 32]));
            hit[i] = longint'($signed(d[126 + 32 * i +: 32]));
        end
        v[0] = -longint'($signed(d[254 +: 32]));
        v[1] = longint'($signed(d[222 +: 32]));
        v[2] = longint'($signed(d[286 +: 32]));
        turn_pair(v[1], v[2], roll);
        turn_pair(v[2], v[0], wrap360(-pitch));
        turn_pair(v[0], v[1], wrap360(90 - yaw));
        mv = 1'b0;
        for (int i = 0; i < 3; i++) begin
            t[i] = clamp32(hit[i] - v[i]);
            diff = t[i] - cur[i];
            if (diff < 0) begin
                diff = -diff;
            end
            if (diff > longint'({33'd0, eps_r})) begin
                mv = 1'b1;
            end
        end
        r.target_x      = t[0][31:0];
        r.target_y      = t[1][31:0];
        r.target_z      = t[2][31:0];
        r.moved         = mv;
        r.write_request = mv & wb_en_r;
        r.row_index     = req_cnt;
        r.moved_total   = mv ? mov_cnt + 16'd1 : mov_cnt;
        return r;
    endfunction

    task automatic check_field(input string name, input logic [31:0] exp_v,
                               input logic [31:0] act_v);
        if (exp_v !== act_v) begin
            $display("%0t: %s mismatch, expected %0h actual %0h", $time, name, exp_v, act_v);
            fails++;
        end
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            eps_r       <= 31'd1;
            wb_en_r     <= 1'b0;
            batch_len_r <= 16'd1;
            req_cnt     <= '0;
            mov_cnt     <= '0;
            pending     <= 0;
            expected_targets.delete();
        end else begin
            if (psel && penable && pwrite && pready) begin
                case (paddr[3:2])
                    REG_MOVE_EPSILON:  eps_r       <= pwdata[30:0];
                    REG_WRITE_BACK_EN: wb_en_r     <= pwdata[0];
                    REG_BATCH_LENGTH:  batch_len_r <= pwdata[15:0];
                    default: ;
                endcase
            end
            if (s_tvalid && s_tready) begin
                want = predict_reground(s_tdata);
                expected_targets.insert(expected_targets.size(), want);
                next_req = req_cnt + 16'd1;
                next_mov = want.moved_total;
                if (next_req == batch_len_r) begin
                    next_req = '0;
                    next_mov = '0;
                end
                req_cnt <= next_req;
                mov_cnt <= next_mov;
            end
            if (m_tvalid && m_tready) begin
                if (expected_targets.size() == 0) begin
                    $display("%0t: result transaction with none expected, expected none actual %0h",
                             $time, m_tdata);
                    fails++;
                end else begin
                    want = expected_targets.pop_front();
                    check_field("target_x", want.target_x, m_tdata[31:0]);
                    check_field("target_y", want.target_y, m_tdata[63:32]);
                    check_field("target_z", want.target_z, m_tdata[95:64]);
                    check_field("moved", 32'(want.moved), 32'(m_tdata[96]));
                    check_field("write_request", 32'(want.write_request), 32'(m_tdata[97]));
                    check_field("row_index", 32'(want.row_index), 32'(m_tdata[113:98]));
                    check_field("moved_total", 32'(want.moved_total), 32'(m_tdata[129:114]));
                end
            end
            pending <= expected_targets.size();
        end
    end

endmodule

// ===== dv/tb.sv =====
// Testbench top for the regrounding core: clock, reset, stimulus, register setup and verdict.
module tb;
    timeunit 1ns;
    timeprecision 1ps;
    import erar_pkg::*;

    localparam int         STALL_LIMIT = 3000;
    localparam int         IDLE_PCT    = 38;
    localparam int         SETTLE      = 30;
    localparam logic [1:0] REG_SPARE   = 2'd3;

    logic                  aclk     = 1'b0;
    logic                  aresetn  = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata  = '0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_tdata;
    logic                  psel     = 1'b0;
    logic                  penable  = 1'b0;
    logic                  pwrite   = 1'b0;
    logic [3:0]            paddr    = '0;
    logic [31:0]           pwdata   = '0;
    logic [31:0]           prdata;
    logic                  pready;
    logic                  gaps_on  = 1'b1;
    int                    fail_count;
    int                    pending;
    int                    quiet    = 0;

    always #6 aclk = ~aclk;

    euler_rotated_anchor_reground_core u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    erar_checker u_checker (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .pready     (pready),
        .fail_count (fail_count),
        .pending    (pending)
    );

    always @(posedge aclk) begin
        if (gaps_on) begin
            m_tready <= ($urandom_range(99) >= IDLE_PCT);
        end else begin
            m_tready <= 1'b1;
        end
    end

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            quiet <= 0;
        end else begin
            quiet <= quiet + 1;
        end
        if (quiet >= STALL_LIMIT) begin
            $display("%0t: no transaction for %0d cycles", $time, quiet);
            $display("CHECKS FAILED");
            $finish;
        end
    end

    function automatic logic [IN_DATA_W-1:0] pack_req(
        input logic [9:0] p, input logic [9:0] y, input logic [9:0] r,
        input logic [31:0] cx, input logic [31:0] cy, input logic [31:0] cz,
        input logic [31:0] hx, input logic [31:0] hy, input logic [31:0] hz,
        input logic [31:0] ax, input logic [31:0] ay, input logic [31:0] az);
        return {2'b00, az, ay, ax, hz, hy, hx, cz, cy, cx, r, y, p};
    endfunction

    function automatic logic [IN_DATA_W-1:0] random_req();
        logic [9:0]  ang [3];
        logic [31:0] hit [3];
        logic [31:0] anc [3];
        logic [31:0] cur [3];
        int          kind;
        int          mag;
        kind = $urandom_range(99);
        mag  = $urandom_range(24, 4);
        for (int i = 0; i < 3; i++) begin
            if ($urandom_range(9) == 0) begin
                ang[i] = 10'($urandom());
            end else begin
                ang[i] = 10'($urandom_range(720) - 360);
            end
            hit[i] = $urandom();
            anc[i] = $urandom() >> (32 - mag);
            if ($urandom_range(1) == 1) begin
                anc[i] = -anc[i];
            end
            if (kind < 30) begin
                anc[i] = '0;
            end
            if (kind < 60) begin
                cur[i] = hit[i] + 32'($urandom_range(8)) - 32'd4;
            end else if (kind < 85) begin
                cur[i] = hit[i] + 32'($urandom_range(2000)) - 32'd1000;
            end else begin
                cur[i] = $urandom();
                anc[i] = $urandom();
            end
        end
        return pack_req(ang[0], ang[1], ang[2], cur[0], cur[1], cur[2],
                        hit[0], hit[1], hit[2], anc[0], anc[1], anc[2]);
    endfunction

    task automatic apb_write(input logic [1:0] idx, input logic [31:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic set_regrounding(input logic [30:0] eps, input logic wbe, input logic [15:0] blen);
        apb_write(REG_MOVE_EPSILON, {1'($urandom()), eps});
        apb_write(REG_WRITE_BACK_EN, ($urandom() & 32'hFFFF_FFFE) | 32'(wbe));
        apb_write(REG_BATCH_LENGTH, {16'($urandom()), blen});
    endtask

    task automatic send_request(input logic [IN_DATA_W-1:0] d);
        while (gaps_on && $urandom_range(99) < IDLE_PCT) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= d;
        @(posedge aclk);
        while (!s_tready) begin
            @(posedge aclk);
        end
    endtask

    task automatic drain_results();
        s_tvalid <= 1'b0;
        do begin
            @(posedge aclk);
        end while (pending != 0);
        repeat (SETTLE) @(posedge aclk);
    endtask

    logic [30:0] eps_set [8];
    logic        wbe_set [8];
    logic [15:0] blen_set [8];

    initial begin
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        send_request(pack_req(10'd0, 10'd0, 10'd0, '0, '0, '0, '0, '0, '0, '0, '0, '0));
        send_request(pack_req(10'd0, 10'd0, 10'd0, 32'd1000, 32'd2000, 32'd3000,
                              32'd1000, 32'd2000, 32'd3000, 32'd256, 32'd512, 32'd768));
        send_request(pack_req(10'd90, 10'd90, 10'd90, 32'd1000, 32'd2000, 32'd3000,
                              32'd1000, 32'd2000, 32'd3000, 32'd256, 32'd512, 32'd768));
        send_request(pack_req(10'd180, -10'sd90, 10'd270, 32'd0, 32'd0, 32'd0,
                              32'd5000, -32'sd5000, 32'd7, 32'd4096, -32'sd8192, 32'd300));
        send_request(pack_req(10'd360, -10'sd360, 10'd360, 32'd9, 32'd9, 32'd9,
                              32'd10, 32'd10, 32'd10, 32'd77, 32'd88, 32'd99));
        send_request(pack_req(10'h1FF, 10'h200, 10'd45, 32'd0, 32'd0, 32'd0,
                              32'd0, 32'd0, 32'd0, 32'd100000, 32'd200000, -32'sd300000));
        send_request(pack_req(10'h3FF, 10'd359, 10'd1, 32'd0, 32'd0, 32'd0,
                              32'd12, 32'd34, 32'd56, -32'sd65536, 32'd65536, 32'd1));
        send_request(pack_req(10'd33, 10'd66, 10'd99, 32'd1001, 32'd2001, 32'd2999,
                              32'd1000, 32'd2000, 32'd3000, '0, '0, '0));
        send_request(pack_req(10'd33, 10'd66, 10'd99, 32'd1000, 32'd1998, 32'd3000,
                              32'd1000, 32'd2000, 32'd3000, '0, '0, '0));
        send_request(pack_req(10'd0, 10'd0, 10'd0, '0, '0, '0, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                              32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000));
        send_request(pack_req(10'd45, 10'd0, 10'd0, '0, '0, '0, 32'h8000_0000, 32'h8000_0000,
                              32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF));
        send_request(pack_req(10'd0, 10'd90, 10'd0, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                              32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, '0, '0, '0));
        send_request(pack_req(10'd30, 10'd60, 10'd120, '0, '0, '0, '0, '0, '0,
                              32'h8000_0000, 32'h8000_0000, 32'h8000_0000));
        send_request(pack_req(10'd359, 10'd359, 10'd359, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                              32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                              32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF));
        send_request(pack_req(10'h3FF, 10'h3FF, 10'h3FF, '1, '1, '1, '1, '1, '1, '1, '1, '1));
        drain_results();

        apb_write(REG_SPARE, $urandom());
        set_regrounding(31'd0, 1'b1, 16'd3);
        send_request(pack_req(10'd10, 10'd20, 10'd30, 32'd5, 32'd5, 32'd5,
                              32'd5, 32'd5, 32'd5, '0, '0, '0));
        send_request(pack_req(10'd10, 10'd20, 10'd30, 32'd5, 32'd6, 32'd5,
                              32'd5, 32'd5, 32'd5, '0, '0, '0));
        send_request(pack_req(10'd200, 10'd300, 10'd100, '0, '0, '0,
                              32'd5, 32'd5, 32'd5, 32'd512, 32'd512, 32'd512));
        send_request(pack_req(10'd200, 10'd300, 10'd100, '0, '0, '0,
                              32'd5, 32'd5, 32'd5, 32'd512, 32'd512, 32'd512));
        drain_results();

        eps_set  = '{31'd0, 31'h7FFF_FFFF, 31'd1000, 31'($urandom()), 31'd3, 31'd200,
                     31'd1, 31'($urandom_range(5000))};
        wbe_set  = '{1'b1, 1'b1, 1'b0, 1'b1, 1'b1, 1'b0, 1'b1, 1'b1};
        blen_set = '{16'd7, 16'd65535, 16'd1, 16'($urandom_range(40, 1)), 16'd0, 16'd12,
                     16'd65535, 16'($urandom_range(9, 2))};

        for (int ph = 0; ph < 8; ph++) begin
            set_regrounding(eps_set[ph], wbe_set[ph], blen_set[ph]);
            gaps_on <= (ph != 3);
            for (int n = 0; n < 190; n++) begin
                send_request(random_req());
                if (ph == 2 && n == 95) begin
                    drain_results();
                end
            end
            drain_results();
        end
        gaps_on <= 1'b1;

        if (fail_count == 0 && pending == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
